// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/bmep_pkg.sv =====
// shared types and constants of the bus mouse event packetizer
`default_nettype none
package bmep_pkg;

   localparam int SUM_WIDTH_DEFAULT = 16;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 32;

   localparam int PKT_LEN   = 5;
   localparam int IDX_WIDTH = $clog2(PKT_LEN);

   localparam logic [IDX_WIDTH-1:0] BYTE_HEADER = IDX_WIDTH'(0);
   localparam logic [IDX_WIDTH-1:0] BYTE_DX     = IDX_WIDTH'(1);
   localparam logic [IDX_WIDTH-1:0] BYTE_DY     = IDX_WIDTH'(2);
   localparam logic [IDX_WIDTH-1:0] BYTE_LAST   = IDX_WIDTH'(PKT_LEN - 1);

   localparam logic [7:0] RAW_MIN     = 8'h80;
   localparam logic [7:0] DX_MIN_FIX  = 8'h81;
   localparam logic [7:0] DY_MIN_FIX  = 8'h7f;
   localparam logic [4:0] HEADER_MARK = 5'b10000;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_REPORT = 1'b1
   } opcode_type;

endpackage
`default_nettype wire

// ===== rtl/bus_mouse_event_packetizer.sv =====
// bus mouse event packetizer: motion samples to five-byte packets, status reports
//
// req channel: one request per beat; req_tuser is the opcode (0 motion sample,
// 1 status report), req_tdata holds the four raw port reads. rsp channel: a
// sample with motion or a button change gives five beats (header, dx, dy, 0, 0,
// tlast on the fifth); a report gives one beat with tuser and tlast high.
// Quiet samples and samples taken while disabled give no beat.
// csr channel: writes the enable bit; csr_ready is always high. Opening the
// device (enable 0 to 1) clears buttons, change flags and sums.
// A request passes the input and then the result register before its first
// beat shows. Throughput: one request per cycle for reports and silent samples
// while rsp_tready is high; a packet-producing sample holds the single result
// register, which sends one packet byte per beat, until its last beat is taken.
// The input register takes the next request while a packet is still being sent.
// Reset clears both registers' valid flags, the enable, buttons and sums.
// When rsp_tready is low the current beat holds; once the input register is
// also full, req_tready drops.
`default_nettype none
`include "assert_macros.svh"
module bus_mouse_event_packetizer #(
   parameter int SUM_WIDTH = bmep_pkg::SUM_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // x_high_read, x_low_read, y_high_read, y_low_read
   input  wire logic [bmep_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // opcode
   input  wire logic                                 req_tuser,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // packet_byte, report_status, report_x, report_y, one zero pad bit
   output      logic [bmep_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // is_report
   output      logic                                 rsp_tuser,
   output      logic                                 rsp_tlast,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic                                 csr_data
);

   localparam int IW = bmep_pkg::IDX_WIDTH;
   localparam logic signed [SUM_WIDTH-1:0] CLAMP_POS = SUM_WIDTH'(127);
   localparam logic signed [SUM_WIDTH-1:0] CLAMP_NEG = -CLAMP_POS;

   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                    input logic [7:0]           d);
      logic [SUM_WIDTH:0] s;
      logic [SUM_WIDTH-1:0] r;
      s = {a[SUM_WIDTH-1], a} + {{(SUM_WIDTH-7){d[7]}}, d};
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         r = s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         r = s[SUM_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] clamp_byte(input logic signed [SUM_WIDTH-1:0] v);
      logic [7:0] r;
      if (v > CLAMP_POS) begin
         r = CLAMP_POS[7:0];
      end else if (v < CLAMP_NEG) begin
         r = CLAMP_NEG[7:0];
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // input register
   logic                                in_valid_ff, in_valid_in;
   bmep_pkg::opcode_type                in_op_ff;
   logic [bmep_pkg::REQ_DATA_WIDTH-1:0] in_data_ff;

   // block state
   logic                 enable_ff, enable_in;
   logic [5:0]           btn_ff, btn_in;
   logic [SUM_WIDTH-1:0] sum_x_ff, sum_x_in;
   logic [SUM_WIDTH-1:0] sum_y_ff, sum_y_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   logic [IW-1:0] out_idx_ff, out_idx_in;
   logic          out_rep_ff;
   logic [7:0]    out_b0_ff, out_dx_ff, out_dy_ff;
   logic [6:0]    out_status_ff;
   logic [7:0]    out_rx_ff, out_ry_ff;

   logic       out_last, out_free, consume, is_report, csr_open;
   logic [7:0] raw_x, raw_y, dx, dy, pkt_byte;
   logic [2:0] buttons, changed;
   logic       moved;
   logic [6:0] status;

   assign out_last   = out_rep_ff || (out_idx_ff == bmep_pkg::BYTE_LAST);
   assign out_free   = !out_valid_ff || (rsp_tready && out_last);
   assign consume    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || consume;
   assign is_report  = (in_op_ff == bmep_pkg::OP_REPORT);
   assign csr_ready  = 1'b1;
   assign csr_open   = csr_valid && csr_data && !enable_ff;

   // sample decode
   assign raw_x   = {in_data_ff[3:0], in_data_ff[11:8]};
   assign raw_y   = {in_data_ff[19:16], in_data_ff[27:24]};
   assign dx      = (raw_x == bmep_pkg::RAW_MIN) ? bmep_pkg::DX_MIN_FIX : raw_x;
   assign dy      = (raw_y == bmep_pkg::RAW_MIN) ? bmep_pkg::DY_MIN_FIX : 8'(8'd0 - raw_y);
   assign buttons = ~in_data_ff[23:21];
   assign changed = buttons ^ btn_ff[2:0];
   assign moved   = (dx != 8'd0) || (dy != 8'd0) || (changed != 3'd0);
   assign status  = {(sum_x_ff != '0) || (sum_y_ff != '0), btn_ff};

   always_comb begin
      in_valid_in  = in_valid_ff;
      enable_in    = enable_ff;
      btn_in       = btn_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;

      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      if (consume) begin
         if (is_report) begin
            sum_x_in     = '0;
            sum_y_in     = '0;
            btn_in       = {3'd0, btn_ff[2:0]};
            out_valid_in = 1'b1;
            out_idx_in   = bmep_pkg::BYTE_HEADER;
         end else if (enable_ff) begin
            btn_in = {btn_ff[5:3] | changed, buttons};
            if (moved) begin
               sum_x_in     = sat_add(sum_x_ff, dx);
               sum_y_in     = sat_add(sum_y_ff, dy);
               out_valid_in = 1'b1;
               out_idx_in   = bmep_pkg::BYTE_HEADER;
            end else begin
               out_valid_in = 1'b0;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (out_valid_ff && rsp_tready) begin
         if (out_last) begin
            out_valid_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + IW'(1);
         end
      end

      if (csr_valid) begin
         enable_in = csr_data;
      end
      if (csr_open) begin
         btn_in   = '0;
         sum_x_in = '0;
         sum_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         enable_ff    <= 1'b0;
         btn_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= bmep_pkg::BYTE_HEADER;
      end else begin
         in_valid_ff  <= in_valid_in;
         enable_ff    <= enable_in;
         btn_ff       <= btn_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= bmep_pkg::opcode_type'(req_tuser);
         in_data_ff <= req_tdata;
      end
      if (consume) begin
         out_rep_ff <= is_report;
         out_b0_ff  <= {bmep_pkg::HEADER_MARK, in_data_ff[23:21]};
         out_dx_ff  <= dx;
         out_dy_ff  <= dy;
         if (is_report) begin
            out_status_ff <= status;
            out_rx_ff     <= clamp_byte(sum_x_ff);
            out_ry_ff     <= clamp_byte(sum_y_ff);
         end else begin
            out_status_ff <= '0;
            out_rx_ff     <= '0;
            out_ry_ff     <= '0;
         end
      end
   end

   always_comb begin
      pkt_byte = 8'd0;
      if (!out_rep_ff) begin
         unique case (out_idx_ff)
            bmep_pkg::BYTE_HEADER: pkt_byte = out_b0_ff;
            bmep_pkg::BYTE_DX:     pkt_byte = out_dx_ff;
            bmep_pkg::BYTE_DY:     pkt_byte = out_dy_ff;
            default:               pkt_byte = 8'd0;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ry_ff, out_rx_ff, out_status_ff, pkt_byte};
   assign rsp_tuser  = out_rep_ff;
   assign rsp_tlast  = out_last;

   `ASSERT_HOLDS(a_idx_range, clock, reset, out_idx_ff <= bmep_pkg::BYTE_LAST)
   `ASSERT_NEXT(a_report_clears, clock, reset, consume && is_report && !csr_open,
                sum_x_ff == '0 && sum_y_ff == '0 && btn_ff[5:3] == 3'd0)
   `ASSERT_NEXT(a_disabled_quiet, clock, reset,
                consume && !is_report && !enable_ff && !csr_valid,
                $stable(sum_x_ff) && $stable(sum_y_ff) && $stable(btn_ff))
   `ASSERT_HOLDS(a_stall_cause, clock, reset, (in_valid_ff && !req_tready) |-> out_valid_ff)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the bus mouse event packetizer: directed and random requests, self-checking
`timescale 1ns / 1ps
module tb;

   localparam int SUM_MAX = (1 << (bmep_pkg::SUM_WIDTH_DEFAULT - 1)) - 1;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
      logic       is_report;
      logic [6:0] status;
      logic [7:0] rep_x;
      logic [7:0] rep_y;
   } mouse_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   // mouse state as the block should hold it
   logic        dev_open;
   logic [5:0]  button_state;
   int          motion_x;
   int          motion_y;

   mouse_beat_type beats_due[$];
   mouse_beat_type seen_beat;
   mouse_beat_type want_beat;
   int             mismatch_count = 0;
   int             send_idle_pct  = 0;
   int             rsp_stall_pct  = 0;

   bus_mouse_event_packetizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int sat_sum(input int acc, input int delta);
      int r;
      r = acc + delta;
      if (r > SUM_MAX) r = SUM_MAX;
      if (r < -SUM_MAX - 1) r = -SUM_MAX - 1;
      return r;
   endfunction

   function automatic logic [7:0] clamp_report(input int v);
      if (v > 127) return 8'd127;
      if (v < -127) return 8'h81;
      return v[7:0];
   endfunction

   function automatic mouse_beat_type packet_beat(input logic [7:0] pb, input logic last);
      return '{packet_byte: pb, last_byte: last, is_report: 1'b0,
               status: 7'd0, rep_x: 8'd0, rep_y: 8'd0};
   endfunction

   function automatic logic [31:0] reads_of(input logic [7:0] xh, input logic [7:0] xl,
                                            input logic [7:0] yh, input logic [7:0] yl);
      return {yl, yh, xl, xh};
   endfunction

   function automatic void predict_request(input bmep_pkg::opcode_type op,
                                           input logic [31:0] reads);
      logic signed [7:0] raw_x;
      logic signed [7:0] raw_y;
      int                dx;
      int                dy;
      logic [2:0]        buttons;
      logic [2:0]        changed;
      logic [6:0]        status;
      if (op == bmep_pkg::OP_REPORT) begin
         status = {1'b0, button_state};
         if (motion_x != 0 || motion_y != 0) status[6] = 1'b1;
         beats_due.push_back('{packet_byte: 8'd0, last_byte: 1'b1, is_report: 1'b1,
                               status: status, rep_x: clamp_report(motion_x),
                               rep_y: clamp_report(motion_y)});
         motion_x = 0;
         motion_y = 0;
         button_state[5:3] = 3'b000;
         return;
      end
      if (!dev_open) return;
      raw_x = {reads[3:0], reads[11:8]};
      raw_y = {reads[19:16], reads[27:24]};
      dx = raw_x;
      dy = -int'(raw_y);
      if (raw_x == -128) dx = -127;
      if (raw_y == -128) dy = 127;
      buttons = ~reads[23:21];
      changed = buttons ^ button_state[2:0];
      button_state = {button_state[5:3] | changed, buttons};
      if (dx == 0 && dy == 0 && changed == 3'b000) return;
      motion_x = sat_sum(motion_x, dx);
      motion_y = sat_sum(motion_y, dy);
      beats_due.push_back(packet_beat(8'h80 | {5'd0, ~buttons}, 1'b0));
      beats_due.push_back(packet_beat(dx[7:0], 1'b0));
      beats_due.push_back(packet_beat(dy[7:0], 1'b0));
      beats_due.push_back(packet_beat(8'd0, 1'b0));
      beats_due.push_back(packet_beat(8'd0, 1'b1));
   endfunction

   // response side: random stalls and comparison
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_beat = '{packet_byte: rsp_tdata[7:0], last_byte: rsp_tlast,
                       is_report: rsp_tuser, status: rsp_tdata[14:8],
                       rep_x: rsp_tdata[22:15], rep_y: rsp_tdata[30:23]};
         if (beats_due.size() == 0) begin
            $error("unexpected response beat %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want_beat = beats_due.pop_front();
            if (seen_beat.packet_byte !== want_beat.packet_byte) begin
               $error("packet_byte expected %h got %h",
                      want_beat.packet_byte, seen_beat.packet_byte);
               mismatch_count++;
            end
            if (seen_beat.last_byte !== want_beat.last_byte) begin
               $error("last_byte expected %b got %b", want_beat.last_byte, seen_beat.last_byte);
               mismatch_count++;
            end
            if (seen_beat.is_report !== want_beat.is_report) begin
               $error("is_report expected %b got %b", want_beat.is_report, seen_beat.is_report);
               mismatch_count++;
            end
            if (seen_beat.status !== want_beat.status) begin
               $error("report_status expected %h got %h", want_beat.status, seen_beat.status);
               mismatch_count++;
            end
            if (seen_beat.rep_x !== want_beat.rep_x) begin
               $error("report_x expected %h got %h", want_beat.rep_x, seen_beat.rep_x);
               mismatch_count++;
            end
            if (seen_beat.rep_y !== want_beat.rep_y) begin
               $error("report_y expected %h got %h", want_beat.rep_y, seen_beat.rep_y);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_request(input bmep_pkg::opcode_type op, input logic [31:0] reads);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= reads;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, reads);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (beats_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      drain_responses();
      // quiet samples may still be in flight
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (value && !dev_open) begin
         button_state = '0;
         motion_x     = 0;
         motion_y     = 0;
      end
      dev_open = value;
   endtask

   task automatic test_disabled_device();
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h03, 8'h04, 8'h05, 8'h06));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'hff, 8'hff, 8'hff, 8'hff));
   endtask

   task automatic test_directed_samples();
      write_enable(1'b1);
      // x of -128, y of -128, then both at +127
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h08, 8'h00, 8'he0, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h07, 8'h0f, 8'he8, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h07, 8'h0f, 8'he7, 8'h0f));
      // unused upper bits set
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'hf0, 8'hf1, 8'hff, 8'hff));
      // quiet, then a button change alone
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'hf0, 8'hf0, 8'hf0, 8'hf0));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h00, 8'hc0, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h00, 8'ha0, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h00, 8'h60, 8'h00));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h08, 8'h00, 8'h67, 8'h0f));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h08, 8'h00, 8'h67, 8'h0f));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'hff, 8'hff, 8'hff, 8'hff));
   endtask

   task automatic test_enable_writes();
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h01, 8'h02, 8'h1f, 8'h0e));
      write_enable(1'b1);
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h00, 8'h09, 8'h00, 8'h03));
      write_enable(1'b0);
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h04, 8'h04, 8'he4, 8'h04));
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h05, 8'h00, 8'h20, 8'h00));
      write_enable(1'b0);
      write_enable(1'b1);
      send_request(bmep_pkg::OP_REPORT, reads_of(8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_report_clamping();
      send_request(bmep_pkg::OP_REPORT, '0);
      // drive x well above and y well below the report range, then partly back
      repeat (6) send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h07, 8'h0f, 8'he7, 8'h0f));
      repeat (4) send_request(bmep_pkg::OP_SAMPLE, reads_of(8'h08, 8'h01, 8'he8, 8'h01));
      send_request(bmep_pkg::OP_REPORT, '0);
   endtask

   task automatic send_random_request();
      logic [31:0] reads;
      reads = $urandom();
      if ($urandom_range(99) < 15) begin
         send_request(bmep_pkg::OP_REPORT, reads);
      end else begin
         case ($urandom_range(9))
            0, 1: begin
               reads[3:0]   = 4'h0;
               reads[11:8]  = 4'h0;
               reads[19:16] = 4'h0;
               reads[27:24] = 4'h0;
            end
            2: begin
               reads[3:0]  = 4'h8;
               reads[11:8] = 4'h0;
            end
            3: begin
               reads[19:16] = 4'h8;
               reads[27:24] = 4'h0;
            end
            default: ;
         endcase
         if ($urandom_range(1)) reads[23:21] = ~button_state[2:0];
         send_request(bmep_pkg::OP_SAMPLE, reads);
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct, input logic open);
      write_enable(open);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_responses();
         send_random_request();
      end
      drain_responses();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      dev_open     = 1'b0;
      button_state = '0;
      motion_x     = 0;
      motion_y     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_device();
      test_directed_samples();
      test_enable_writes();
      test_report_clamping();
      test_random_traffic(30, 0, 0, 1'b1);
      test_random_traffic(30, 79, 0, 1'b1);
      test_random_traffic(15, 0, 79, 1'b0);
      test_random_traffic(30, 0, 79, 1'b1);
      test_random_traffic(30, 15, 15, 1'b1);
      drain_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
